// ===== hdl/assert_macros.svh =====
// Assertion macros for the modules that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/mrf_pkg.sv =====
// Shared types and codes of the message ring FIFO.
`timescale 1ns / 1ps
package mrf_pkg;

   localparam int FUNC_W      = 2;
   localparam int STATUS_W    = 3;
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 7;
   localparam int COUNT_OUT_W = 5;

   localparam logic [FUNC_W-1:0] FUNC_POST  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_PEND  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_BYTE_TAKEN = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL       = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_TOO_LONG   = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_EMPTY      = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_CLEARED    = 3'd5;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic post;        // store one posted byte and answer it
      logic pend_empty;  // answer a pend on an empty queue
      logic pend_start;  // pop the head slot and fetch its first byte
      logic pend_emit;   // deliver the fetched byte, fetch the next one
      logic clear;       // drop everything
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;    // output register can take a word this cycle
      logic count_zero;  // no message held
      logic pend_last;   // fetched byte is the final one of the message
   } stat_type;

endpackage

// ===== hdl/mrf_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module mrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/mrf_ctrl.sv =====
// Controller of the message ring FIFO: input handshake and pend sequencing.
`timescale 1ns / 1ps
module mrf_ctrl import mrf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [FUNC_W-1:0] req_func,
   output logic              req_stall,
   input  stat_type          stat,
   output cmd_type           cmd
);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_STREAM = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   // Items are taken only between pends and only with room at the output.
   assign req_stall = !((state_ff == ST_IDLE) && stat.out_free);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_POST:  cmd.post = 1'b1;
                  FUNC_CLEAR: cmd.clear = 1'b1;
                  FUNC_PEND: begin
                     if (stat.count_zero) begin
                        cmd.pend_empty = 1'b1;
                     end else begin
                        cmd.pend_start = 1'b1;
                        state_in       = ST_STREAM;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_STREAM: begin
            if (stat.out_free) begin
               cmd.pend_emit = 1'b1;
               if (stat.pend_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/mrf_dp.sv =====
// Datapath of the message ring FIFO: queue pointers, stores and output register.
`timescale 1ns / 1ps
module mrf_dp import mrf_pkg::*; #(
   parameter int QUEUE_SLOTS   = 16,
   parameter int MAX_MSG_BYTES = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output stat_type               stat,
   input  logic [BYTE_W-1:0]      req_data_byte,
   input  logic                   req_byte_last,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [BYTE_W-1:0]      rsp_out_byte,
   output logic [LEN_W-1:0]       rsp_msg_length,
   output logic                   rsp_out_last,
   output logic [COUNT_OUT_W-1:0] rsp_entry_count
);

   localparam int SLOT_W    = $clog2(QUEUE_SLOTS);
   localparam int CNT_W     = $clog2(QUEUE_SLOTS + 1);
   localparam int WO_W      = $clog2(MAX_MSG_BYTES + 1);
   localparam int MSG_DEPTH = QUEUE_SLOTS * MAX_MSG_BYTES;
   localparam int ADDR_W    = $clog2(MSG_DEPTH);

   logic [SLOT_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [WO_W-1:0]   wo_ff, wo_in;
   logic              ovl_ff, ovl_in;
   logic [WO_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [ADDR_W-1:0] pend_base_ff, pend_base_in;

   logic                   rsp_valid_ff;
   logic [STATUS_W-1:0]    status_ff;
   logic [BYTE_W-1:0]      out_byte_ff;
   logic [LEN_W-1:0]       msg_length_ff;
   logic                   out_last_ff;
   logic [COUNT_OUT_W-1:0] entry_count_ff;

   logic                res_load;
   logic [STATUS_W-1:0] res_status;
   logic [BYTE_W-1:0]   res_byte;
   logic [LEN_W-1:0]    res_length;

   logic [CNT_W:0]      tail_sum;
   logic [SLOT_W-1:0]   tail_slot;
   logic [ADDR_W-1:0]   tail_base;
   logic [ADDR_W-1:0]   head_base;
   logic                full;
   logic                byte_fits;
   logic [WO_W-1:0]     wo_next;
   logic                ovl_next;
   logic                commit;

   logic                msg_wr_en;
   logic                msg_rd_en;
   logic [ADDR_W-1:0]   msg_rd_addr;
   logic [BYTE_W-1:0]   msg_rd_data;
   logic [LEN_W-1:0]    len_rd_data;

   // Tail slot is head plus count, wrapped once.
   assign tail_sum  = (CNT_W+1)'(head_ff) + (CNT_W+1)'(count_ff);
   assign tail_slot = (tail_sum >= (CNT_W+1)'(QUEUE_SLOTS))
                      ? SLOT_W'(tail_sum - (CNT_W+1)'(QUEUE_SLOTS))
                      : SLOT_W'(tail_sum);
   assign tail_base = ADDR_W'(tail_slot) * ADDR_W'(MAX_MSG_BYTES);
   assign head_base = ADDR_W'(head_ff) * ADDR_W'(MAX_MSG_BYTES);

   assign full      = (count_ff == CNT_W'(QUEUE_SLOTS));
   assign byte_fits = !ovl_ff && (wo_ff < WO_W'(MAX_MSG_BYTES));
   assign wo_next   = byte_fits ? wo_ff + 1'b1 : wo_ff;
   assign ovl_next  = !byte_fits;
   assign commit    = cmd.post && req_byte_last && !ovl_next && !full;
   assign msg_wr_en = cmd.post && byte_fits && !full;

   assign msg_rd_en   = cmd.pend_start || (cmd.pend_emit && !stat.pend_last);
   assign msg_rd_addr = cmd.pend_start ? head_base
                        : pend_base_ff + ADDR_W'(rd_idx_ff) + 1'b1;

   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;
   assign stat.count_zero = (count_ff == '0);
   assign stat.pend_last  = ((LEN_W+1)'(rd_idx_ff) + 1'b1) >= (LEN_W+1)'(len_rd_data);

   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      wo_in        = wo_ff;
      ovl_in       = ovl_ff;
      rd_idx_in    = rd_idx_ff;
      pend_base_in = pend_base_ff;
      res_load     = 1'b0;
      res_status   = STAT_OK;
      res_byte     = '0;
      res_length   = '0;

      if (cmd.post) begin
         res_load = 1'b1;
         if (!req_byte_last) begin
            res_status = STAT_BYTE_TAKEN;
            wo_in      = wo_next;
            ovl_in     = ovl_next;
         end else begin
            wo_in  = '0;
            ovl_in = 1'b0;
            if (ovl_next) begin
               res_status = STAT_TOO_LONG;
            end else if (full) begin
               res_status = STAT_FULL;
            end else begin
               res_length = LEN_W'(wo_next);
               count_in   = count_ff + 1'b1;
            end
         end
      end

      if (cmd.pend_empty) begin
         res_load   = 1'b1;
         res_status = STAT_EMPTY;
      end

      if (cmd.pend_start) begin
         head_in      = (head_ff == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : head_ff + 1'b1;
         count_in     = count_ff - 1'b1;
         pend_base_in = head_base;
         rd_idx_in    = '0;
      end

      if (cmd.pend_emit) begin
         res_load   = 1'b1;
         res_byte   = msg_rd_data;
         res_length = len_rd_data;
         if (!stat.pend_last) begin
            rd_idx_in = rd_idx_ff + 1'b1;
         end
      end

      if (cmd.clear) begin
         head_in    = '0;
         count_in   = '0;
         wo_in      = '0;
         ovl_in     = 1'b0;
         res_load   = 1'b1;
         res_status = STAT_CLEARED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         wo_ff        <= '0;
         ovl_ff       <= 1'b0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff   <= head_in;
         count_ff  <= count_in;
         wo_ff     <= wo_in;
         ovl_ff    <= ovl_in;
         rd_idx_ff <= rd_idx_in;
         if (res_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_base_ff <= pend_base_in;
      if (res_load) begin
         status_ff      <= res_status;
         out_byte_ff    <= res_byte;
         msg_length_ff  <= res_length;
         out_last_ff    <= !cmd.pend_emit || stat.pend_last;
         entry_count_ff <= COUNT_OUT_W'(count_in);
      end
   end

   mrf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MSG_DEPTH)
   ) u_msg_ram (
      .clock   (clock),
      .wr_en   (msg_wr_en),
      .wr_addr (tail_base + ADDR_W'(wo_ff)),
      .wr_data (req_data_byte),
      .rd_en   (msg_rd_en),
      .rd_addr (msg_rd_addr),
      .rd_data (msg_rd_data)
   );

   mrf_ram #(
      .WIDTH (LEN_W),
      .DEPTH (QUEUE_SLOTS)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (tail_slot),
      .wr_data (LEN_W'(wo_next)),
      .rd_en   (cmd.pend_start),
      .rd_addr (head_ff),
      .rd_data (len_rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_msg_length  = msg_length_ff;
   assign rsp_out_last    = out_last_ff;
   assign rsp_entry_count = entry_count_ff;

endmodule

// ===== hdl/message_ring_fifo.sv =====
// Top level of the message ring FIFO: controller, datapath and checks.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// The block keeps up to QUEUE_SLOTS messages of 1 to MAX_MSG_BYTES bytes in
// a ring. A post word carries one byte; the word with byte_last set commits
// the message, or answers full or too long. A pend word returns the oldest
// message as one response word per byte, each with the message length, and
// out_last on the final byte; on an empty queue it returns one word with the
// empty status. A clear word drops every message and any partial post. Every
// response word carries the number of messages held afterwards. A message
// streams in at one byte per cycle while the response side does not stall.
// A pend holds the input while it first reads the length store and the first
// byte from the message memory, then delivers one byte per cycle from that
// memory's registered read port while the response side does not stall.
// Both stores come out of reset unwritten and need no clearing pass; the
// block accepts words right after reset.
module message_ring_fifo import mrf_pkg::*; #(
   parameter int QUEUE_SLOTS   = 16,
   parameter int MAX_MSG_BYTES = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [FUNC_W-1:0]      req_func,
   input  logic [BYTE_W-1:0]      req_data_byte,
   input  logic                   req_byte_last,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [BYTE_W-1:0]      rsp_out_byte,
   output logic [LEN_W-1:0]       rsp_msg_length,
   output logic                   rsp_out_last,
   output logic [COUNT_OUT_W-1:0] rsp_entry_count
);

   cmd_type  cmd;
   stat_type stat;

   // The controller owns the input handshake and walks a pend through its
   // bytes; it only sees a few status flags from the datapath.
   mrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the ring pointers, the partial post state, both
   // stores and the response register.
   mrf_dp #(
      .QUEUE_SLOTS   (QUEUE_SLOTS),
      .MAX_MSG_BYTES (MAX_MSG_BYTES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_data_byte   (req_data_byte),
      .req_byte_last   (req_byte_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_msg_length  (rsp_msg_length),
      .rsp_out_last    (rsp_out_last),
      .rsp_entry_count (rsp_entry_count)
   );

   // A blocked response word must hold off new input words.
   `ASSERT_IMPLIES(a_stall_back, clock, reset, rsp_valid && rsp_stall, req_stall)
   // Only a pend produces more than one word, and those carry a length.
   `ASSERT_IMPLIES(a_multi_word_pend, clock, reset, rsp_valid && !rsp_out_last, rsp_status == STAT_OK && rsp_msg_length != '0)
   // A clear empties the queue.
   `ASSERT_IMPLIES(a_clear_empty, clock, reset, rsp_valid && rsp_status == STAT_CLEARED, rsp_entry_count == '0)
   // An accepted clear word answers in the next cycle.
   `ASSERT_NEXT(a_clear_answer, clock, reset, req_valid && !req_stall && req_func == FUNC_CLEAR, rsp_valid && rsp_status == STAT_CLEARED)

endmodule

// ===== dv/message_ring_fifo_test.sv =====
// Self-checking testbench for the message ring FIFO.
`timescale 1ns / 1ps
module message_ring_fifo_test import mrf_pkg::*;;

   localparam int QUEUE_SLOTS   = 16;
   localparam int MAX_MSG_BYTES = 64;

   // The one func code the block does not define; such a word is dropped silently.
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   localparam int RANDOM_WORDS = 150;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 80;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int PRINT_LIMIT  = 40;

   // One response word, laid out field by field as the rsp_ ports carry it.
   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [BYTE_W-1:0]      out_byte;
      logic [LEN_W-1:0]       msg_length;
      logic                   out_last;
      logic [COUNT_OUT_W-1:0] entry_count;
   } rsp_word_type;

   // One row of the directed stimulus. A row is sent "repeats" times, and the
   // data byte steps up by one on each repeat. Rows whose answer is obvious
   // carry it in the pin_ fields; every other row is checked against the
   // ring model below.
   typedef struct packed {
      logic [FUNC_W-1:0]      func;
      logic [BYTE_W-1:0]      data;
      logic                   last;
      logic [7:0]             repeats;
      logic                   pinned;
      logic [STATUS_W-1:0]    pin_status;
      logic [LEN_W-1:0]       pin_len;
      logic [COUNT_OUT_W-1:0] pin_count;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 24;

   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // A pend on the queue straight out of reset finds it empty.
      '{FUNC_PEND,   8'h00, 1'b0, 8'd1,  1'b1, STAT_EMPTY,      7'd0,  5'd0},
      // Two one-byte messages with the extreme byte values.
      '{FUNC_POST,   8'h00, 1'b1, 8'd1,  1'b1, STAT_OK,         7'd1,  5'd1},
      '{FUNC_POST,   8'hFF, 1'b1, 8'd1,  1'b1, STAT_OK,         7'd1,  5'd2},
      '{FUNC_PEND,   8'h00, 1'b0, 8'd1,  1'b1, STAT_OK,         7'd1,  5'd1},
      '{FUNC_PEND,   8'h00, 1'b0, 8'd1,  1'b0, STAT_OK,         7'd0,  5'd0},
      // A message of the largest length, committed and then read back.
      '{FUNC_POST,   8'h01, 1'b0, 8'd63, 1'b1, STAT_BYTE_TAKEN, 7'd0,  5'd0},
      '{FUNC_POST,   8'hC3, 1'b1, 8'd1,  1'b1, STAT_OK,         7'd64, 5'd1},
      '{FUNC_PEND,   8'h00, 1'b0, 8'd1,  1'b0, STAT_OK,         7'd0,  5'd0},
      // One byte too many: the byte past the limit makes the message too long.
      '{FUNC_POST,   8'h80, 1'b0, 8'd64, 1'b1, STAT_BYTE_TAKEN, 7'd0,  5'd0},
      '{FUNC_POST,   8'h7E, 1'b1, 8'd1,  1'b1, STAT_TOO_LONG,   7'd0,  5'd0},
      // The undefined func code gives no answer at all.
      '{FUNC_UNUSED, 8'hFF, 1'b1, 8'd1,  1'b0, STAT_OK,         7'd0,  5'd0},
      // A pend in the middle of a post leaves the partial message alone.
      '{FUNC_POST,   8'h5A, 1'b0, 8'd1,  1'b1, STAT_BYTE_TAKEN, 7'd0,  5'd0},
      '{FUNC_PEND,   8'h00, 1'b0, 8'd1,  1'b1, STAT_EMPTY,      7'd0,  5'd0},
      '{FUNC_POST,   8'hA5, 1'b1, 8'd1,  1'b1, STAT_OK,         7'd2,  5'd1},
      // A clear drops both the held message and a partial post.
      '{FUNC_POST,   8'h33, 1'b0, 8'd1,  1'b1, STAT_BYTE_TAKEN, 7'd0,  5'd1},
      '{FUNC_CLEAR,  8'h00, 1'b0, 8'd1,  1'b1, STAT_CLEARED,    7'd0,  5'd0},
      '{FUNC_PEND,   8'h00, 1'b0, 8'd1,  1'b1, STAT_EMPTY,      7'd0,  5'd0},
      // Fill every slot, then offer one more message.
      '{FUNC_POST,   8'h10, 1'b1, 8'd16, 1'b0, STAT_OK,         7'd0,  5'd0},
      '{FUNC_POST,   8'hEE, 1'b1, 8'd1,  1'b1, STAT_FULL,       7'd0,  5'd16},
      // Start a post while full; a pend frees the slot before its last byte,
      // so the message commits with its first byte left from the earlier one.
      '{FUNC_POST,   8'h44, 1'b0, 8'd1,  1'b1, STAT_BYTE_TAKEN, 7'd0,  5'd16},
      '{FUNC_PEND,   8'h00, 1'b0, 8'd1,  1'b0, STAT_OK,         7'd0,  5'd0},
      '{FUNC_POST,   8'h99, 1'b1, 8'd1,  1'b1, STAT_OK,         7'd2,  5'd16},
      '{FUNC_PEND,   8'h00, 1'b0, 8'd1,  1'b0, STAT_OK,         7'd0,  5'd0},
      '{FUNC_CLEAR,  8'h00, 1'b0, 8'd1,  1'b1, STAT_CLEARED,    7'd0,  5'd0}
   };

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [FUNC_W-1:0]      req_func;
   logic [BYTE_W-1:0]      req_data_byte;
   logic                   req_byte_last;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [STATUS_W-1:0]    rsp_status;
   logic [BYTE_W-1:0]      rsp_out_byte;
   logic [LEN_W-1:0]       rsp_msg_length;
   logic                   rsp_out_last;
   logic [COUNT_OUT_W-1:0] rsp_entry_count;

   message_ring_fifo #(
      .QUEUE_SLOTS  (QUEUE_SLOTS),
      .MAX_MSG_BYTES(MAX_MSG_BYTES)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_data_byte  (req_data_byte),
      .req_byte_last  (req_byte_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_msg_length (rsp_msg_length),
      .rsp_out_last   (rsp_out_last),
      .rsp_entry_count(rsp_entry_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow copy of the ring. The written flags track which message bytes
   // hold a defined value, so that the stimulus never commits a message that
   // would later read back a byte that was never stored.
   logic [BYTE_W-1:0] ring_bytes [QUEUE_SLOTS*MAX_MSG_BYTES];
   bit                ring_written [QUEUE_SLOTS*MAX_MSG_BYTES];
   logic [LEN_W-1:0]  ring_lengths [QUEUE_SLOTS];
   int                ring_head;
   int                ring_held;
   int                post_offset;
   bit                post_overlong;

   // Response words that the ring model says are still owed, oldest first.
   rsp_word_type due_words [$];

   int  mismatch_count;
   int  words_taken;
   int  cycle_count;
   bit  calm;
   bit  hold_request;

   function automatic int tail_slot();
      return (ring_head + ring_held) % QUEUE_SLOTS;
   endfunction

   task automatic owe_word(input logic [STATUS_W-1:0] status, input logic [BYTE_W-1:0] data,
                           input int msg_len, input logic last);
      due_words.push_back('{status, data, LEN_W'(msg_len), last, COUNT_OUT_W'(ring_held)});
   endtask

   // Advance the shadow ring by one accepted word and queue the words it owes.
   task automatic apply_to_ring(input logic [FUNC_W-1:0] func, input logic [BYTE_W-1:0] data,
                                input logic last);
      int slot;
      int msg_len;
      case (func)
         FUNC_POST: begin
            if (post_overlong || post_offset >= MAX_MSG_BYTES) begin
               post_overlong = 1'b1;
            end else begin
               // Bytes posted while every slot is taken are counted but not stored.
               if (ring_held < QUEUE_SLOTS) begin
                  ring_bytes[tail_slot()*MAX_MSG_BYTES + post_offset] = data;
                  ring_written[tail_slot()*MAX_MSG_BYTES + post_offset] = 1'b1;
               end
               post_offset++;
            end
            if (!last) begin
               owe_word(STAT_BYTE_TAKEN, '0, 0, 1'b1);
            end else begin
               if (post_overlong) begin
                  owe_word(STAT_TOO_LONG, '0, 0, 1'b1);
               end else if (ring_held >= QUEUE_SLOTS) begin
                  owe_word(STAT_FULL, '0, 0, 1'b1);
               end else begin
                  ring_lengths[tail_slot()] = LEN_W'(post_offset);
                  ring_held++;
                  owe_word(STAT_OK, '0, post_offset, 1'b1);
               end
               post_offset = 0;
               post_overlong = 1'b0;
            end
         end
         FUNC_PEND: begin
            if (ring_held == 0) begin
               owe_word(STAT_EMPTY, '0, 0, 1'b1);
            end else begin
               slot = ring_head;
               msg_len = ring_lengths[slot];
               ring_head = (slot + 1) % QUEUE_SLOTS;
               ring_held--;
               for (int i = 0; i < msg_len; i++)
                  owe_word(STAT_OK, ring_bytes[slot*MAX_MSG_BYTES + i], msg_len,
                           i == msg_len - 1);
            end
         end
         FUNC_CLEAR: begin
            ring_head = 0;
            ring_held = 0;
            post_offset = 0;
            post_overlong = 1'b0;
            owe_word(STAT_CLEARED, '0, 0, 1'b1);
         end
         default: ;
      endcase
   endtask

   // True when this word would commit a message in which some byte was
   // skipped and never stored earlier in that slot.
   function automatic bit commit_reads_unwritten(input logic [FUNC_W-1:0] func,
                                                 input logic last);
      int base;
      if (func != FUNC_POST || !last || post_overlong || post_offset >= MAX_MSG_BYTES
          || ring_held >= QUEUE_SLOTS)
         return 1'b0;
      base = tail_slot() * MAX_MSG_BYTES;
      for (int k = 0; k < post_offset; k++)
         if (!ring_written[base + k])
            return 1'b1;
      return 1'b0;
   endfunction

   // Idle stretches: mostly none or short, now and then a long one. While
   // calm is set no new random idle stretch starts on either side.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (calm || r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   task automatic flag_error(input string what, input logic [7:0] got, input logic [7:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // Offer one word, hold it until the block takes it, then update the model.
   // A final post byte that would commit an ill-defined message goes out as a
   // clear instead.
   task automatic offer_word(input logic [FUNC_W-1:0] func, input logic [BYTE_W-1:0] data,
                             input logic last, input logic pinned = 1'b0,
                             input rsp_word_type pin = '0);
      int gap;
      int owed_before;
      logic [FUNC_W-1:0] sent_func;
      sent_func = commit_reads_unwritten(func, last) ? FUNC_CLEAR : func;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= sent_func;
      req_data_byte <= data;
      req_byte_last <= last;
      do @(posedge clock); while (req_stall);
      owed_before = due_words.size();
      apply_to_ring(sent_func, data, last);
      // A pinned row answers with exactly one word, typed in by hand.
      if (pinned && due_words.size() > owed_before)
         due_words[$] = pin;
      if (sent_func != FUNC_UNUSED) begin
         words_taken++;
         if (words_taken % 20 == 0)
            calm = ($urandom_range(3) == 0);
      end
   endtask

   function automatic int pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 70)
         return $urandom_range(1, 4);
      if (r < 88)
         return $urandom_range(5, 16);
      if (r < 95)
         return $urandom_range(MAX_MSG_BYTES - 4, MAX_MSG_BYTES);
      return $urandom_range(MAX_MSG_BYTES + 1, MAX_MSG_BYTES + 4);
   endfunction

   // A whole message with random bytes. Now and then a pend cuts in between
   // two bytes, and rarely a clear abandons the message.
   task automatic post_message(input int n);
      for (int i = 0; i < n; i++) begin
         if (i > 0 && $urandom_range(15) == 0)
            offer_word(FUNC_PEND, BYTE_W'($urandom), 1'($urandom));
         if (i > 0 && $urandom_range(60) == 0) begin
            offer_word(FUNC_CLEAR, BYTE_W'($urandom), 1'($urandom));
            return;
         end
         offer_word(FUNC_POST, BYTE_W'($urandom), i == n - 1);
      end
   endtask

   // Stimulus and end of run.
   initial begin
      rsp_word_type pin;
      int           goal;
      int           r;
      bit           filling;
      bit           hold_issued;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_func      = FUNC_POST;
      req_data_byte = '0;
      req_byte_last = 1'b0;
      rsp_stall     = 1'b0;
      ring_head     = 0;
      ring_held     = 0;
      post_offset   = 0;
      post_overlong = 1'b0;
      mismatch_count = 0;
      words_taken   = 0;
      calm          = 1'b0;
      hold_request  = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         pin = '{DIRECTED[row].pin_status, '0, DIRECTED[row].pin_len, 1'b1,
                 DIRECTED[row].pin_count};
         for (int k = 0; k < DIRECTED[row].repeats; k++)
            offer_word(DIRECTED[row].func, BYTE_W'(DIRECTED[row].data + k),
                       DIRECTED[row].last, DIRECTED[row].pinned, pin);
      end

      // Random part. The mix swings between filling the ring up to full and
      // draining it nearly empty, so both ends of the ring are visited often.
      // The receiver is told to hold off for a long stretch right away and
      // again halfway through, while words keep coming.
      hold_request = 1'b1;
      hold_issued  = 1'b0;
      filling      = 1'b1;
      goal         = words_taken + RANDOM_WORDS;
      while (words_taken < goal) begin
         if (filling && ring_held == QUEUE_SLOTS)
            filling = 1'b0;
         else if (!filling && ring_held <= 1)
            filling = 1'b1;
         if (!hold_issued && words_taken >= goal - RANDOM_WORDS / 2) begin
            hold_request = 1'b1;
            hold_issued  = 1'b1;
         end
         r = $urandom_range(99);
         if (r < (filling ? 82 : 40))
            post_message(pick_length());
         else if (r < (filling ? 95 : 86))
            offer_word(FUNC_PEND, BYTE_W'($urandom), 1'($urandom));
         else if (r < (filling ? 96 : 92))
            offer_word(FUNC_CLEAR, BYTE_W'($urandom), 1'($urandom));
         else if (r < 97)
            offer_word(FUNC_UNUSED, BYTE_W'($urandom), 1'($urandom));
         else
            offer_word(FUNC_POST, BYTE_W'($urandom), 1'($urandom));
      end
      req_valid <= 1'b0;

      // Wait for every owed word, then a little longer to catch strays.
      while (due_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // Response side: check each accepted word against the oldest owed one,
   // then pick the stall for the next cycle.
   initial begin
      rsp_word_type want;
      int           stall_left;
      int           hold_left;
      stall_left = 0;
      hold_left  = 0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            if (due_words.size() == 0) begin
               flag_error("word with none owed, status", 8'(rsp_status), 8'd0);
            end else begin
               want = due_words.pop_front();
               if (rsp_status !== want.status)
                  flag_error("status", 8'(rsp_status), 8'(want.status));
               if (rsp_out_byte !== want.out_byte)
                  flag_error("out_byte", rsp_out_byte, want.out_byte);
               if (rsp_msg_length !== want.msg_length)
                  flag_error("msg_length", 8'(rsp_msg_length), 8'(want.msg_length));
               if (rsp_out_last !== want.out_last)
                  flag_error("out_last", 8'(rsp_out_last), 8'(want.out_last));
               if (rsp_entry_count !== want.entry_count)
                  flag_error("entry_count", 8'(rsp_entry_count), 8'(want.entry_count));
            end
         end
         if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (!calm && $urandom_range(4) == 0)
               stall_left = pick_gap();
         end
      end
   end

   // Watchdog for a block that stops answering.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/mrf_pkg.sv
hdl/mrf_ram.sv
hdl/mrf_ctrl.sv
hdl/mrf_dp.sv
hdl/message_ring_fifo.sv
dv/message_ring_fifo_test.sv
